// File: rtl/dsjfd_pkg.sv
// Package: shared constants, types and helpers of the dual-sensor jerk fall detector.
`default_nettype none
package dsjfd_pkg;

    // Window and decision period
    localparam int WINDOW           = 16;
    localparam int DECISION_WINDOWS = 4;
    localparam int POS_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int WIN_W = (DECISION_WINDOWS > 1) ? $clog2(DECISION_WINDOWS) : 1;

    // Datapath widths
    localparam int AXIS_W = 16;            // Q8.8 axis sample
    localparam int MAG_W  = 16;            // |difference| of two axis samples
    localparam int SQ_W   = 2 * MAG_W + 2; // sum of three squares
    localparam int ROOT_W = SQ_W / 2;      // floor square root
    localparam int SUM_W  = 32;            // saturating jerk sum

    // Serial step counts
    localparam int MUL_STEPS = MAG_W;      // one multiplier bit per cycle
    localparam int RT_STEPS  = ROOT_W;     // one root bit per cycle
    localparam int CNT_W     = $clog2(RT_STEPS + 1);

    // Control of a serial unit
    typedef struct packed {
        logic load;
        logic step;
    } t_ser_ctrl;

    // Sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_SQ,
        S_RT_A,
        S_RT_B,
        S_DONE
    } t_state;

    // Magnitude of the difference of two signed axis samples
    function automatic logic [MAG_W-1:0] abs_diff(input logic [AXIS_W-1:0] cur,
                                                   input logic [AXIS_W-1:0] prev);
        logic [AXIS_W:0] d;
        logic [AXIS_W:0] m;
        d = {cur[AXIS_W-1], cur} - {prev[AXIS_W-1], prev};
        m = d[AXIS_W] ? (~d + 1'b1) : d;
        return m[MAG_W-1:0];
    endfunction

endpackage
`default_nettype wire

// File: rtl/dsjfd_sqsum.sv
// Bit-serial sum of three squares: one multiplier bit of each axis per cycle while step is high.
`default_nettype none
module dsjfd_sqsum import dsjfd_pkg::*; (
    input  wire logic              i_clk,
    input  wire t_ser_ctrl         i_ctrl,
    input  wire logic [MAG_W-1:0]  i_mag_x,
    input  wire logic [MAG_W-1:0]  i_mag_y,
    input  wire logic [MAG_W-1:0]  i_mag_z,
    output logic      [SQ_W-1:0]   o_sum
);

    localparam int HI_W = SQ_W - MAG_W;

    logic [MAG_W-1:0] r_mx, r_my, r_mz;
    logic [MAG_W-1:0] r_bx, r_by, r_bz;
    logic [HI_W-1:0]  r_hi;
    logic [MAG_W-1:0] r_lo;

    logic [HI_W-1:0]  w_part;
    logic [HI_W:0]    w_acc;

    // Partial product of this bit position over all three axes
    always_comb begin
        w_part = (r_bx[0] ? HI_W'(r_mx) : '0)
               + (r_by[0] ? HI_W'(r_my) : '0)
               + (r_bz[0] ? HI_W'(r_mz) : '0);
        w_acc  = {1'b0, r_hi} + {1'b0, w_part};
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.load) begin
            r_mx <= i_mag_x;
            r_my <= i_mag_y;
            r_mz <= i_mag_z;
            r_bx <= i_mag_x;
            r_by <= i_mag_y;
            r_bz <= i_mag_z;
            r_hi <= '0;
            r_lo <= '0;
        end else if (i_ctrl.step) begin
            // Add, then shift the product right by one
            r_bx <= r_bx >> 1;
            r_by <= r_by >> 1;
            r_bz <= r_bz >> 1;
            r_hi <= w_acc[HI_W:1];
            r_lo <= {w_acc[0], r_lo[MAG_W-1:1]};
        end
    end

    assign o_sum = {r_hi, r_lo};

endmodule
`default_nettype wire

// File: rtl/dsjfd_isqrt.sv
// Digit-recurrence integer square root: one root bit per cycle while step is high.
`default_nettype none
module dsjfd_isqrt import dsjfd_pkg::*; (
    input  wire logic              i_clk,
    input  wire t_ser_ctrl         i_ctrl,
    input  wire logic [SQ_W-1:0]   i_rad,
    output logic      [ROOT_W-1:0] o_root
);

    localparam int REM_W = ROOT_W + 1;

    logic [SQ_W-1:0]   r_rad;
    logic [REM_W-1:0]  r_rem;
    logic [ROOT_W-1:0] r_root;

    logic [REM_W+1:0]  w_sh;
    logic [REM_W+1:0]  w_trial;
    logic [REM_W+1:0]  w_diff;
    logic              w_ge;

    // Bring down the next two radicand bits and try root*4+1
    always_comb begin
        w_sh    = {r_rem, r_rad[SQ_W-1 -: 2]};
        w_trial = {1'b0, r_root, 2'b01};
        w_diff  = w_sh - w_trial;
        w_ge    = (w_sh >= w_trial);
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.load) begin
            r_rad  <= i_rad;
            r_rem  <= '0;
            r_root <= '0;
        end else if (i_ctrl.step) begin
            r_rad  <= {r_rad[SQ_W-3:0], 2'b00};
            r_rem  <= w_ge ? w_diff[REM_W-1:0] : w_sh[REM_W-1:0];
            r_root <= {r_root[ROOT_W-2:0], w_ge};
        end
    end

    assign o_root = r_root;

endmodule
`default_nettype wire

// File: rtl/dual_sensor_jerk_fall_detector.sv
// Top level: dual-sensor jerk fall detector with serial squaring and a shared square root.
//
// Usage. Each input request carries one paired sample of two three-axis
// accelerometers (signed Q8.8). It is taken when i_in_valid and o_in_ready are
// both high; o_in_ready is high only while the sequencer is idle, so one sample
// is in work at a time. The two sum-of-squares units run in parallel, one
// multiplier bit per cycle, then the shared square-root unit runs once for
// each sensor, one root bit per cycle, each run begun by a load. The final
// state updates the sums, counters and indicator and fills the output
// register. The next sample is therefore accepted only after the previous one
// is finished, a pace set by the bit-serial multiplier and the shared root unit.
// The output request is held in its register until i_out_ready takes it; a
// stalled receiver holds the result and, once the next sample is finished,
// holds the sequencer in its final state. The next sample may be accepted
// while a result waits.
// The threshold is written through the configuration channel, which is always
// ready; write it only while the block is idle.
// Reset (synchronous, active low) clears the previous samples, sums, counters
// and indicator, sets the threshold to all ones and empties the output register.
`default_nettype none
module dual_sensor_jerk_fall_detector import dsjfd_pkg::*; (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    // configuration channel
    input  wire logic               i_cfg_valid,
    output logic                    o_cfg_ready,
    input  wire logic [SUM_W-1:0]   i_cfg_data,
    // input channel
    input  wire logic               i_in_valid,
    output logic                    o_in_ready,
    input  wire logic [AXIS_W-1:0]  i_first_x,
    input  wire logic [AXIS_W-1:0]  i_first_y,
    input  wire logic [AXIS_W-1:0]  i_first_z,
    input  wire logic [AXIS_W-1:0]  i_second_x,
    input  wire logic [AXIS_W-1:0]  i_second_y,
    input  wire logic [AXIS_W-1:0]  i_second_z,
    // output channel
    output logic                    o_out_valid,
    input  wire logic               i_out_ready,
    output logic                    o_decision_valid,
    output logic                    o_fall_detected,
    output logic                    o_indicator_on,
    output logic      [SUM_W-1:0]   o_first_sum_out,
    output logic      [SUM_W-1:0]   o_second_sum_out
);

    // Sequencer
    t_state           r_state, n_state;
    logic [CNT_W-1:0] r_cnt, n_cnt;

    // Architectural state
    logic [AXIS_W-1:0] r_pa_x, r_pa_y, r_pa_z;
    logic [AXIS_W-1:0] r_pb_x, r_pb_y, r_pb_z;
    logic [POS_W-1:0]  r_pos;
    logic [WIN_W-1:0]  r_win;
    logic [SUM_W-1:0]  r_acc_a, r_acc_b;
    logic              r_ind;
    logic [SUM_W-1:0]  r_thr;

    // Output register
    logic              r_out_valid;
    logic              r_dec, r_fall, r_ind_out;
    logic [SUM_W-1:0]  r_sum_a, r_sum_b;

    // Root of the first sensor, held while the second runs
    logic [ROOT_W-1:0] r_root_a;

    logic              w_accept;
    logic              w_finish;
    logic              w_take_a;
    t_ser_ctrl         w_sq_ctrl;
    t_ser_ctrl         w_rt_ctrl;
    logic [SQ_W-1:0]   w_sq_a, w_sq_b, w_rad;
    logic [ROOT_W-1:0] w_root;

    // Update values for the closing cycle
    logic [SUM_W:0]    w_add_a, w_add_b;
    logic [SUM_W-1:0]  w_s1, w_s2;
    logic              w_pos_last, w_win_last, w_dec, w_fall;

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = (r_state == S_IDLE);
    assign w_accept    = i_in_valid && o_in_ready;

    // Serial datapath units: one sum of squares per sensor, one shared root
    dsjfd_sqsum u_sq_a (
        .i_clk   (i_clk),
        .i_ctrl  (w_sq_ctrl),
        .i_mag_x (abs_diff(i_first_x, r_pa_x)),
        .i_mag_y (abs_diff(i_first_y, r_pa_y)),
        .i_mag_z (abs_diff(i_first_z, r_pa_z)),
        .o_sum   (w_sq_a)
    );

    dsjfd_sqsum u_sq_b (
        .i_clk   (i_clk),
        .i_ctrl  (w_sq_ctrl),
        .i_mag_x (abs_diff(i_second_x, r_pb_x)),
        .i_mag_y (abs_diff(i_second_y, r_pb_y)),
        .i_mag_z (abs_diff(i_second_z, r_pb_z)),
        .o_sum   (w_sq_b)
    );

    assign w_rad = (r_state == S_RT_B) ? w_sq_b : w_sq_a;

    dsjfd_isqrt u_rt (
        .i_clk   (i_clk),
        .i_ctrl  (w_rt_ctrl),
        .i_rad   (w_rad),
        .o_root  (w_root)
    );

    // Closing arithmetic: saturating sums, window and decision bookkeeping
    always_comb begin
        w_add_a    = {1'b0, r_acc_a} + (SUM_W + 1)'(r_root_a);
        w_add_b    = {1'b0, r_acc_b} + (SUM_W + 1)'(w_root);
        // The first sample of a window adds nothing
        if (r_pos != '0) begin
            w_s1 = w_add_a[SUM_W] ? '1 : w_add_a[SUM_W-1:0];
            w_s2 = w_add_b[SUM_W] ? '1 : w_add_b[SUM_W-1:0];
        end else begin
            w_s1 = r_acc_a;
            w_s2 = r_acc_b;
        end
        w_pos_last = (r_pos == POS_W'(WINDOW - 1));
        w_win_last = (r_win == WIN_W'(DECISION_WINDOWS - 1));
        w_dec      = w_pos_last && w_win_last;
        w_fall     = w_dec && (w_s1 > r_thr) && (w_s2 > r_thr);
    end

    // Next state and unit control
    always_comb begin
        n_state   = r_state;
        n_cnt     = r_cnt;
        w_sq_ctrl = '0;
        w_rt_ctrl = '0;
        w_take_a  = 1'b0;
        w_finish  = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    w_sq_ctrl.load = 1'b1;
                    n_state        = S_SQ;
                    n_cnt          = '0;
                end
            end
            S_SQ: begin
                w_sq_ctrl.step = 1'b1;
                if (r_cnt == CNT_W'(MUL_STEPS - 1)) begin
                    n_state = S_RT_A;
                    n_cnt   = '0;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            S_RT_A: begin
                if (r_cnt == '0) begin
                    w_rt_ctrl.load = 1'b1;
                end else begin
                    w_rt_ctrl.step = 1'b1;
                end
                if (r_cnt == CNT_W'(RT_STEPS)) begin
                    n_state = S_RT_B;
                    n_cnt   = '0;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            S_RT_B: begin
                if (r_cnt == '0) begin
                    // Keep the first root, load the second radicand
                    w_take_a       = 1'b1;
                    w_rt_ctrl.load = 1'b1;
                end else begin
                    w_rt_ctrl.step = 1'b1;
                end
                if (r_cnt == CNT_W'(RT_STEPS)) begin
                    n_state = S_DONE;
                    n_cnt   = '0;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            S_DONE: begin
                // Hold until the output register is free
                if (!r_out_valid || i_out_ready) begin
                    w_finish = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
                n_cnt   = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    // Architectural state and output request
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pa_x      <= '0;
            r_pa_y      <= '0;
            r_pa_z      <= '0;
            r_pb_x      <= '0;
            r_pb_y      <= '0;
            r_pb_z      <= '0;
            r_pos       <= '0;
            r_win       <= '0;
            r_acc_a     <= '0;
            r_acc_b     <= '0;
            r_ind       <= 1'b0;
            r_thr       <= '1;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                r_thr <= i_cfg_data;
            end
            // The magnitudes are taken at acceptance, so advance the history now
            if (w_accept) begin
                r_pa_x <= i_first_x;
                r_pa_y <= i_first_y;
                r_pa_z <= i_first_z;
                r_pb_x <= i_second_x;
                r_pb_y <= i_second_y;
                r_pb_z <= i_second_z;
            end
            if (w_finish) begin
                r_out_valid <= 1'b1;
                if (w_pos_last) begin
                    r_pos <= '0;
                    r_ind <= w_fall;
                    if (w_win_last) begin
                        r_win   <= '0;
                        r_acc_a <= '0;
                        r_acc_b <= '0;
                    end else begin
                        r_win   <= r_win + 1'b1;
                        r_acc_a <= w_s1;
                        r_acc_b <= w_s2;
                    end
                end else begin
                    r_pos   <= r_pos + 1'b1;
                    r_acc_a <= w_s1;
                    r_acc_b <= w_s2;
                end
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (w_take_a) begin
            r_root_a <= w_root;
        end
        if (w_finish) begin
            r_dec     <= w_dec;
            r_fall    <= w_fall;
            r_ind_out <= w_pos_last ? w_fall : r_ind;
            r_sum_a   <= w_s1;
            r_sum_b   <= w_s2;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_decision_valid = r_dec;
    assign o_fall_detected  = r_fall;
    assign o_indicator_on   = r_ind_out;
    assign o_first_sum_out  = r_sum_a;
    assign o_second_sum_out = r_sum_b;

`ifndef SYNTHESIS
    a_fall_needs_decision: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_fall) |-> r_dec)
        else $error("fall flagged outside a decision");

    a_fall_sets_indicator: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_fall) |-> r_ind_out)
        else $error("fall flagged with indicator off");

    a_accept_starts_squaring: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state == S_SQ) && (r_cnt == '0))
        else $error("accepted sample did not start squaring");

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_W'(RT_STEPS))
        else $error("step counter out of range");

    a_finish_needs_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_finish |-> (!r_out_valid || i_out_ready))
        else $error("result overwrote a waiting request");
`endif

endmodule
`default_nettype wire
